@@ src/csvfs_pkg.sv @@
// Shared types and constants for the CSV field splitter.
package csvfs_pkg;

    // Input beat: one line byte or an end-of-line marker
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } csvfs_in_t;

    // Result beat: one field boundary or one line-level status
    typedef struct packed {
        logic [2:0]  status;
        logic [12:0] field_index;
        logic [11:0] field_start;
        logic [12:0] field_length;
        logic        last_field;
    } csvfs_out_t;

    typedef enum logic [2:0] {
        MODE_START  = 3'd0,
        MODE_PLAIN  = 3'd1,
        MODE_QUOTED = 3'd2,
        MODE_CLOSED = 3'd3,
        MODE_DROP   = 3'd4
    } scan_mode_t;

    localparam logic [2:0] ST_FIELD   = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_UNTERM  = 3'd2;
    localparam logic [2:0] ST_JUNK    = 3'd3;
    localparam logic [2:0] ST_TOOLONG = 3'd4;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOL  = 1'b1;

    localparam logic REG_DELIMITER = 1'b0;
    localparam logic REG_QUOTE     = 1'b1;

    localparam logic [7:0] DELIMITER_RESET = 8'd44;
    localparam logic [7:0] QUOTE_RESET     = 8'd34;

endpackage

@@ src/csv_field_splitter.sv @@
// CSV field splitter top level: per-byte scanner with a registered result stage.
// Results are registered; a result that finds m_ stalled waits in the skid register.
// Throughput: one input beat per cycle; a skid register takes a second result while
// m_ready is low, so s_ready drops only while both result registers hold a result.
// Reset (aresetn low, synchronous): scanner returns to field start at offset zero,
// result registers empty, delimiter and quote return to ',' and '"'.
module csv_field_splitter #(
    parameter int MAX_LINE = 4096
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  csvfs_pkg::csvfs_in_t   s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output csvfs_pkg::csvfs_out_t  m_data,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [7:0]             cfg_wdata
);
    import csvfs_pkg::*;

    localparam int POS_W = $clog2(MAX_LINE + 1);

    logic [7:0]       delim_reg;
    logic [7:0]       quote_reg;
    scan_mode_t       mode_reg, mode_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] begin_reg, begin_next;
    logic [POS_W-1:0] num_reg, num_next;
    logic             m_valid_reg, m_valid_next;
    csvfs_out_t       res_reg, res_next;
    logic             skid_valid_reg, skid_valid_next;
    csvfs_out_t       skid_reg, skid_next;
    csvfs_out_t       res;
    logic             res_valid;
    logic             s_fire;
    logic             m_pop;
    logic             is_quote, is_delim, too_long;
    logic [POS_W-1:0] cur_len;

    assign s_ready  = !skid_valid_reg;
    assign s_fire   = s_valid && s_ready;
    assign m_pop    = m_valid_reg && m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = res_reg;

    assign is_quote = (s_data.data_byte == quote_reg);
    assign is_delim = (s_data.data_byte == delim_reg);
    assign too_long = (pos_reg == POS_W'(MAX_LINE));
    assign cur_len  = pos_reg - begin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg <= DELIMITER_RESET;
            quote_reg <= QUOTE_RESET;
        end else if (cfg_we) begin
            if (cfg_index == REG_DELIMITER) begin
                delim_reg <= cfg_wdata;
            end else begin
                quote_reg <= cfg_wdata;
            end
        end
    end

    // next scan mode
    always_comb begin
        mode_next = mode_reg;
        if (s_fire) begin
            if (s_data.kind == KIND_EOL) begin
                mode_next = MODE_START;
            end else if (mode_reg != MODE_DROP) begin
                if (too_long) begin
                    mode_next = MODE_DROP;
                end else begin
                    case (mode_reg)
                        MODE_START: begin
                            if (is_quote)      mode_next = MODE_QUOTED;
                            else if (is_delim) mode_next = MODE_START;
                            else               mode_next = MODE_PLAIN;
                        end
                        MODE_PLAIN: begin
                            if (is_delim) mode_next = MODE_START;
                        end
                        MODE_QUOTED: begin
                            if (is_quote) mode_next = MODE_CLOSED;
                        end
                        MODE_CLOSED: begin
                            if (is_quote)      mode_next = MODE_QUOTED;
                            else if (is_delim) mode_next = MODE_START;
                            else               mode_next = MODE_DROP;
                        end
                        default: mode_next = MODE_DROP;
                    endcase
                end
            end
        end
    end

    // result and line counters
    always_comb begin
        res_valid          = 1'b0;
        res.status         = ST_FIELD;
        res.field_index    = 13'(num_reg);
        res.field_start    = 12'(begin_reg);
        res.field_length   = 13'(cur_len);
        res.last_field     = 1'b0;
        pos_next           = pos_reg;
        begin_next         = begin_reg;
        num_next           = num_reg;
        if (s_fire) begin
            if (s_data.kind == KIND_EOL) begin
                pos_next   = '0;
                begin_next = '0;
                num_next   = '0;
                res.last_field = 1'b1;
                if (mode_reg == MODE_QUOTED) begin
                    res_valid        = 1'b1;
                    res.status       = ST_UNTERM;
                    res.field_length = '0;
                end else if (mode_reg == MODE_DROP) begin
                    res_valid = 1'b0;
                end else if (pos_reg == '0) begin
                    res_valid = 1'b1;
                    res.status = ST_EMPTY;
                    res.field_index  = '0;
                    res.field_start  = '0;
                    res.field_length = '0;
                end else begin
                    res_valid = 1'b1;
                end
            end else if (mode_reg != MODE_DROP) begin
                if (too_long) begin
                    res_valid        = 1'b1;
                    res.status       = ST_TOOLONG;
                    res.field_length = '0;
                    res.last_field   = 1'b1;
                end else if (mode_reg == MODE_CLOSED && !is_quote && !is_delim) begin
                    // junk after closing quote: position is not advanced
                    res_valid        = 1'b1;
                    res.status       = ST_JUNK;
                    res.field_length = '0;
                    res.last_field   = 1'b1;
                end else begin
                    pos_next = pos_reg + POS_W'(1);
                    // quote test wins over delimiter in START and CLOSED
                    if (is_delim && !(is_quote && mode_reg != MODE_PLAIN)
                        && mode_reg != MODE_QUOTED) begin
                        res_valid  = 1'b1;
                        begin_next = pos_reg + POS_W'(1);
                        num_next   = num_reg + POS_W'(1);
                    end
                end
            end
        end
    end

    // output stage: the skid register catches a result while m_ is stalled
    always_comb begin
        m_valid_next    = m_valid_reg;
        res_next        = res_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            if (m_pop) begin
                res_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (s_fire && res_valid) begin
            if (!m_valid_reg || m_pop) begin
                m_valid_next = 1'b1;
                res_next     = res;
            end else begin
                skid_valid_next = 1'b1;
                skid_next       = res;
            end
        end else if (m_pop) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_START;
            pos_reg        <= '0;
            begin_reg      <= '0;
            num_reg        <= '0;
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            mode_reg       <= mode_next;
            pos_reg        <= pos_next;
            begin_reg      <= begin_next;
            num_reg        <= num_next;
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg  <= res_next;
        skid_reg <= skid_next;
    end

endmodule

@@ src/csvfs_checker.sv @@
// Port-level checks for the CSV field splitter, bound to the top level.
module csvfs_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input csvfs_pkg::csvfs_out_t m_data
);
    import csvfs_pkg::*;

    // a result beat that is not taken holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // every non-field status closes the line
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_FIELD |-> m_data.last_field)
        else $error("line status without last_field");

    // empty line result is all zero
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_EMPTY |->
            m_data.field_index == '0 && m_data.field_start == '0
            && m_data.field_length == '0)
        else $error("empty line result carries nonzero fields");

    // error results report zero length
    a_err_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_UNTERM || m_data.status == ST_JUNK
            || m_data.status == ST_TOOLONG) |-> m_data.field_length == '0)
        else $error("error result with nonzero length");

    // space in the result stage means the input side can take a beat
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result stage");

endmodule

bind csv_field_splitter csvfs_checker u_csvfs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for csv_field_splitter: directed lines, long lines, random lines.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import csvfs_pkg::*;

    localparam int MAX_LINE = 4096;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    csvfs_in_t  s_data  = '0;
    logic       m_valid;
    logic       m_ready = 1'b1;
    csvfs_out_t m_data;
    logic       cfg_we    = 1'b0;
    logic       cfg_index = REG_DELIMITER;
    logic [7:0] cfg_wdata = '0;

    csv_field_splitter #(.MAX_LINE(MAX_LINE)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Scanner state mirrored by the predictor
    logic [7:0]  delim_reg    = DELIMITER_RESET;
    logic [7:0]  quote_reg    = QUOTE_RESET;
    scan_mode_t  line_mode    = MODE_START;
    logic [12:0] line_pos     = '0;
    logic [12:0] field_offset = '0;
    logic [12:0] field_count  = '0;

    csvfs_out_t expected_fields[$];
    csvfs_out_t want_beat;
    int         mismatches = 0;
    int         items_sent = 0;
    bit         no_idle    = 1'b0;
    int         stall_left = 0;

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        mismatches++;
        $display("MISMATCH %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
    endtask

    function automatic void add_byte(ref logic [7:0] q[$], input logic [7:0] v);
        q.insert(q.size(), v);
    endfunction

    function automatic bit close_field(output csvfs_out_t res);
        res = '0;
        res.status       = ST_FIELD;
        res.field_index  = field_count;
        res.field_start  = field_offset[11:0];
        res.field_length = line_pos - field_offset;
        field_offset = line_pos + 13'd1;
        field_count  = field_count + 13'd1;
        line_mode    = MODE_START;
        return 1'b1;
    endfunction

    // Advances the mirrored scanner by one beat; returns 1 when a result is due
    function automatic bit scan_byte(input csvfs_in_t beat, output csvfs_out_t res);
        bit emit;
        logic [7:0] b;
        emit = 1'b0;
        b    = beat.data_byte;
        res  = '0;
        if (beat.kind == KIND_EOL) begin
            if (line_mode != MODE_DROP) begin
                emit = 1'b1;
                res.last_field = 1'b1;
                if (line_mode == MODE_QUOTED) begin
                    res.status      = ST_UNTERM;
                    res.field_index = field_count;
                    res.field_start = field_offset[11:0];
                end else if (line_pos == '0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.status       = ST_FIELD;
                    res.field_index  = field_count;
                    res.field_start  = field_offset[11:0];
                    res.field_length = line_pos - field_offset;
                end
            end
            line_mode    = MODE_START;
            line_pos     = '0;
            field_offset = '0;
            field_count  = '0;
            return emit;
        end
        if (line_mode == MODE_DROP)
            return 1'b0;
        if (int'(line_pos) >= MAX_LINE) begin
            res.status      = ST_TOOLONG;
            res.field_index = field_count;
            res.field_start = field_offset[11:0];
            res.last_field  = 1'b1;
            line_mode = MODE_DROP;
            return 1'b1;
        end
        case (line_mode)
            MODE_START: begin
                if (b == quote_reg)
                    line_mode = MODE_QUOTED;
                else if (b == delim_reg)
                    emit = close_field(res);
                else
                    line_mode = MODE_PLAIN;
            end
            MODE_PLAIN: begin
                if (b == delim_reg)
                    emit = close_field(res);
            end
            MODE_QUOTED: begin
                if (b == quote_reg)
                    line_mode = MODE_CLOSED;
            end
            default: begin
                // closing quote seen: escaped quote, delimiter, or junk
                if (b == quote_reg) begin
                    line_mode = MODE_QUOTED;
                end else if (b == delim_reg) begin
                    emit = close_field(res);
                end else begin
                    res.status      = ST_JUNK;
                    res.field_index = field_count;
                    res.field_start = field_offset[11:0];
                    res.last_field  = 1'b1;
                    line_mode = MODE_DROP;
                    return 1'b1;
                end
            end
        endcase
        line_pos = line_pos + 13'd1;
        return emit;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Result-side backpressure: mostly short stalls, a few long ones
    always @(negedge aclk) begin
        if (!aresetn || no_idle) begin
            stall_left = 0;
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < 20) begin
            stall_left = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 2)
                                                     : $urandom_range(5, 25);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_fields.size() == 0) begin
                report_mismatch("result beat with nothing expected", 0, 1);
            end else begin
                want_beat = expected_fields.pop_front();
                if (m_data.status != want_beat.status)
                    report_mismatch("status", int'(want_beat.status),
                                    int'(m_data.status));
                if (m_data.field_index != want_beat.field_index)
                    report_mismatch("field_index", int'(want_beat.field_index),
                                    int'(m_data.field_index));
                if (m_data.field_start != want_beat.field_start)
                    report_mismatch("field_start", int'(want_beat.field_start),
                                    int'(m_data.field_start));
                if (m_data.field_length != want_beat.field_length)
                    report_mismatch("field_length", int'(want_beat.field_length),
                                    int'(m_data.field_length));
                if (m_data.last_field != want_beat.last_field)
                    report_mismatch("last_field", int'(want_beat.last_field),
                                    int'(m_data.last_field));
            end
        end
    end

    // Called right after a posedge; returns at the posedge where the beat is taken
    task automatic send_beat(input csvfs_in_t beat);
        int gap;
        csvfs_out_t res;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (scan_byte(beat, res))
            expected_fields.insert(expected_fields.size(), res);
    endtask

    task automatic send_line(ref logic [7:0] line_q[$]);
        csvfs_in_t beat;
        foreach (line_q[i]) begin
            beat.kind      = KIND_DATA;
            beat.data_byte = line_q[i];
            send_beat(beat);
        end
        beat.kind      = KIND_EOL;
        beat.data_byte = 8'($urandom_range(1, 255));
        send_beat(beat);
    endtask

    task automatic send_text(input string text);
        logic [7:0] line_q[$];
        for (int i = 0; i < text.len(); i++)
            add_byte(line_q, text[i]);
        send_line(line_q);
    endtask

    // Hold input off until every expected result is out and the pipe is quiet
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_fields.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        drain();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_DELIMITER)
            delim_reg = value;
        else
            quote_reg = value;
    endtask

    function automatic logic [7:0] pick_other();
        logic [7:0] v;
        do v = 8'($urandom_range(1, 255)); while (v == delim_reg || v == quote_reg);
        return v;
    endfunction

    function automatic logic [7:0] pick_noise();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0)
            return delim_reg;
        if (r == 1)
            return quote_reg;
        return pick_other();
    endfunction

    // Mostly well-formed lines with random content; some broken, some pure noise
    task automatic gen_line(ref logic [7:0] line_q[$]);
        int flavor, nfields, sel, len;
        bit broken;
        line_q.delete();
        flavor = $urandom_range(0, 99);
        if (flavor < 8) begin
            len = $urandom_range(0, 12);
            repeat (len) add_byte(line_q, pick_noise());
            return;
        end
        broken  = (flavor < 20);
        nfields = $urandom_range(0, 6);
        for (int f = 0; f < nfields; f++) begin
            if (f > 0)
                add_byte(line_q, delim_reg);
            sel = $urandom_range(0, 9);
            if (sel < 2) begin
                // empty field
            end else if (sel < 6) begin
                len = $urandom_range(1, 6);
                add_byte(line_q, pick_other());
                repeat (len - 1)
                    add_byte(line_q, ($urandom_range(0, 9) == 0) ? quote_reg : pick_other());
            end else begin
                add_byte(line_q, quote_reg);
                len = $urandom_range(0, 5);
                repeat (len) begin
                    sel = $urandom_range(0, 9);
                    if (sel < 6) begin
                        add_byte(line_q, pick_other());
                    end else if (sel < 8) begin
                        add_byte(line_q, delim_reg);
                    end else begin
                        add_byte(line_q, quote_reg);
                        add_byte(line_q, quote_reg);
                    end
                end
                if (broken && f == nfields - 1 && $urandom_range(0, 1) == 0)
                    return;     // left open: unterminated quote
                add_byte(line_q, quote_reg);
                if (broken && f == nfields - 1) begin
                    // junk after the closing quote, then more bytes to drop
                    add_byte(line_q, pick_other());
                    len = $urandom_range(0, 4);
                    repeat (len) add_byte(line_q, pick_noise());
                end
            end
        end
        if ($urandom_range(0, 9) == 0)
            add_byte(line_q, delim_reg);
    endtask

    task automatic test_basic_lines();
        send_text("");
        send_text("a,,\"b\"\"c\",");
        send_text("\"x\"y,z");
        drain();
        send_text("\"q");
        send_text("\377\001");
        send_text("p\"r,\"\"");
    endtask

    task automatic test_register_settings();
        // same byte for both: the quote meaning wins
        write_reg(REG_DELIMITER, 8'd59);
        write_reg(REG_QUOTE, 8'd59);
        send_text(";;;b");
        send_text(";;");
        write_reg(REG_DELIMITER, 8'd1);
        write_reg(REG_QUOTE, 8'd255);
        send_text("\377A\377\001\001");
        write_reg(REG_DELIMITER, 8'd255);
        write_reg(REG_QUOTE, 8'd1);
        send_text("\001\377\001\001\001\377B");
        write_reg(REG_DELIMITER, DELIMITER_RESET);
        write_reg(REG_QUOTE, QUOTE_RESET);
    endtask

    task automatic test_long_lines();
        logic [7:0] line_q[$];
        // trailing delimiter at the last offset: final empty field starts at MAX_LINE
        line_q.delete();
        repeat (MAX_LINE - 1) add_byte(line_q, 8'h61);
        add_byte(line_q, delim_reg);
        send_line(line_q);
        // one quoted field filling the whole line
        line_q.delete();
        add_byte(line_q, quote_reg);
        repeat (MAX_LINE - 2) add_byte(line_q, 8'h62);
        add_byte(line_q, quote_reg);
        send_line(line_q);
        // overflow, with trailing bytes that must be dropped
        line_q.delete();
        repeat (MAX_LINE) add_byte(line_q, 8'h63);
        add_byte(line_q, delim_reg);
        add_byte(line_q, quote_reg);
        add_byte(line_q, 8'h64);
        send_line(line_q);
        // overflow while inside an open quote
        line_q.delete();
        add_byte(line_q, quote_reg);
        repeat (MAX_LINE) add_byte(line_q, 8'h65);
        send_line(line_q);
    endtask

    task automatic test_random_lines();
        logic [7:0] line_q[$];
        logic [7:0] d, q;
        int target;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    d = DELIMITER_RESET;
                    q = QUOTE_RESET;
                end
                1: begin
                    d = 8'd9;
                    q = 8'd39;
                end
                default: begin
                    d = 8'($urandom_range(1, 255));
                    do q = 8'($urandom_range(1, 255)); while (q == d);
                end
            endcase
            write_reg(REG_DELIMITER, d);
            write_reg(REG_QUOTE, q);
            target = items_sent + 475;
            while (items_sent < target) begin
                no_idle = ($urandom_range(0, 99) < 12);
                if ($urandom_range(0, 99) < 3)
                    drain();
                gen_line(line_q);
                send_line(line_q);
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_basic_lines();
        test_register_settings();
        test_long_lines();
        test_random_lines();

        @(negedge aclk);
        s_valid <= 1'b0;
        for (int n = 0; n < 50000 && expected_fields.size() != 0; n++)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (expected_fields.size() != 0)
            report_mismatch("results never produced", 0, expected_fields.size());
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ csv_field_splitter.f @@
src/csvfs_pkg.sv
src/csv_field_splitter.sv
src/csvfs_checker.sv
tb/tb_top.sv
